FILE: hdl/vnan_pkg.sv
// shared types and constants for the vertex normal accumulate and normalize block
`timescale 1ns / 1ps
`default_nettype none
package vnan_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int SUM_WIDTH_DEF    = 24;

  localparam int IDX_W    = 12;
  localparam int CMD_W    = 2;
  localparam int FACE_W   = 16;
  localparam int UNIT_W   = 16;
  localparam int FRAC_W   = 14;
  localparam int Q_W      = FRAC_W + 1;
  localparam int C2_W     = 2 * Q_W;
  localparam int CNT_W    = 6;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int MINLEN_W = 16;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register index is the word address, paddr[2]
  localparam logic REG_MIN_LEN = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_MEM,
    ST_RD_WAIT,
    ST_SQ_START,
    ST_SQ_RUN,
    ST_DEG_CHK,
    ST_T_START,
    ST_T_RUN,
    ST_C2_START,
    ST_C2_RUN,
    ST_CL_START,
    ST_CL_RUN,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } mul_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/vnan_in_if.sv
// command channel: valid, ready and one command transaction
`timescale 1ns / 1ps
`default_nettype none
interface vnan_in_if;
  logic                                valid;
  logic                                ready;
  logic        [vnan_pkg::CMD_W-1:0]   cmd;
  logic        [vnan_pkg::IDX_W-1:0]   vertex_a;
  logic        [vnan_pkg::IDX_W-1:0]   vertex_b;
  logic        [vnan_pkg::IDX_W-1:0]   vertex_c;
  logic signed [vnan_pkg::FACE_W-1:0]  face_x;
  logic signed [vnan_pkg::FACE_W-1:0]  face_y;
  logic signed [vnan_pkg::FACE_W-1:0]  face_z;

  modport source (output valid, cmd, vertex_a, vertex_b, vertex_c, face_x, face_y, face_z,
                  input ready);
  modport sink (input valid, cmd, vertex_a, vertex_b, vertex_c, face_x, face_y, face_z,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/vnan_out_if.sv
// result channel: valid, ready and one result transaction
`timescale 1ns / 1ps
`default_nettype none
interface vnan_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [vnan_pkg::UNIT_W-1:0]  unit_x;
  logic signed [vnan_pkg::UNIT_W-1:0]  unit_y;
  logic signed [vnan_pkg::UNIT_W-1:0]  unit_z;
  logic                                degenerate;
  logic                                overflowed;

  modport source (output valid, unit_x, unit_y, unit_z, degenerate, overflowed, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, degenerate, overflowed, output ready);
endinterface
`default_nettype wire

FILE: hdl/vertex_normal_accumulate_normalize_core.sv
// vertex normal accumulate and normalize core, top level
// usage:
//   in_if carries commands: clear a vertex sum, accumulate a face normal into
//   three vertices, or read one vertex as a Q1.14 unit vector. every command
//   returns one result transaction on out_if. min_length_squared is written
//   over the APB port (psel/penable/pwrite, word address 0) while idle.
// sequencing, one command at a time:
//   clear is a single write state; accumulate does a memory read-modify-write
//   per vertex for the three vertices; a read squares and sums the three
//   components and stops there if degenerate. a full read then finds per
//   component a target from its square and 15 trial bits, each trial squared
//   and scaled by the length squared; every product uses the bit-serial multiplier.
// reset:
//   clears control state and the threshold. the sum memory is not cleared:
//   the host must clear every vertex before use.
// stall:
//   the result waits in an output register; the next command is accepted
//   meanwhile, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module vertex_normal_accumulate_normalize_core #(
  parameter int VERTEX_DEPTH = vnan_pkg::VERTEX_DEPTH_DEF,
  parameter int SUM_WIDTH    = vnan_pkg::SUM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  vnan_in_if.sink                            in_if,
  vnan_out_if.source                         out_if,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [vnan_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [vnan_pkg::CFG_DW-1:0]   pwdata,
  output logic      [vnan_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready
);

  localparam int AW  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int SW  = SUM_WIDTH;
  localparam int EW  = 3 * SW;
  localparam int PW  = 2 * SW + 32;
  localparam int MPW = (SW > vnan_pkg::C2_W) ? SW : vnan_pkg::C2_W;
  localparam int XW  = 17;

  // configuration
  logic [vnan_pkg::MINLEN_W-1:0] min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == vnan_pkg::REG_MIN_LEN)) begin
      min_len_r <= pwdata[vnan_pkg::MINLEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vnan_pkg::REG_MIN_LEN) ?
                  vnan_pkg::CFG_DW'(min_len_r) : '0;

  // command registers
  vnan_pkg::state_t state_r, state_nxt;
  logic [vnan_pkg::CMD_W-1:0]          cmd_r;
  logic [vnan_pkg::IDX_W-1:0]          vtx_r [3];
  logic signed [vnan_pkg::FACE_W-1:0]  face_r [3];
  logic [1:0]                          v_r;
  logic [1:0]                          j_r;
  logic [3:0]                          k_r;
  logic [vnan_pkg::Q_W-1:0]            q_r;
  logic [SW-1:0]                       mag_r [3];
  logic                                neg_r [3];
  logic [PW-1:0]                       len2_r;
  logic [PW-1:0]                       tgt_r;
  logic signed [vnan_pkg::UNIT_W-1:0]  res_r [3];
  logic                                degen_r;
  logic                                ovf_r;
  logic                                inr_r;

  logic in_acc;
  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == vnan_pkg::ST_IDLE);

  // output register
  logic                                out_valid_r;
  logic signed [vnan_pkg::UNIT_W-1:0]  out_unit_r [3];
  logic                                out_degen_r;
  logic                                out_ovf_r;
  logic                                done;
  logic                                out_free;

  assign out_free = !out_valid_r || out_if.ready;

  // sum memory
  logic [EW-1:0] mem [VERTEX_DEPTH];
  logic [EW-1:0] rdata_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [EW-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rdata_r <= mem[mem_addr];
  end

  logic [vnan_pkg::IDX_W-1:0] vsel;
  logic                       vsel_inr;

  assign vsel     = vtx_r[v_r];
  assign vsel_inr = XW'(vsel) < XW'(VERTEX_DEPTH);
  assign mem_addr = AW'(vsel);

  // saturating add of the face normal
  logic [EW-1:0] sat_sum;
  logic          sat_ovf;

  always_comb begin
    logic [SW:0] s;
    sat_ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = {rdata_r[i*SW+SW-1], rdata_r[i*SW +: SW]}
          + (SW+1)'(face_r[i]);
      if (s[SW] != s[SW-1]) begin
        sat_ovf = 1'b1;
        sat_sum[i*SW +: SW] = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        sat_sum[i*SW +: SW] = s[SW-1:0];
      end
    end
  end

  // magnitudes of the read sums
  logic [SW-1:0] rd_mag [3];
  logic          rd_neg [3];

  always_comb begin
    logic [SW-1:0] s;
    for (int i = 0; i < 3; i++) begin
      s         = inr_r ? rdata_r[i*SW +: SW] : '0;
      rd_neg[i] = s[SW-1];
      rd_mag[i] = s[SW-1] ? (~s + 1'b1) : s;
    end
  end

  // serial multiplier
  vnan_pkg::mul_ctl_t mul_ctl;
  logic [PW-1:0]      mul_init;
  logic [PW-1:0]      mul_mcand;
  logic [MPW-1:0]     mul_mplier;
  logic [PW-1:0]      mul_acc;
  logic               mul_busy;

  vnan_serial_mul #(
    .PW  (PW),
    .MPW (MPW)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mul_ctl),
    .acc_init  (mul_init),
    .mcand_in  (mul_mcand),
    .mplier_in (mul_mplier),
    .acc_out   (mul_acc),
    .busy      (mul_busy)
  );

  logic [vnan_pkg::Q_W-1:0] trial;
  logic [vnan_pkg::Q_W-1:0] q_new;
  logic                     is_degen;

  assign trial    = q_r | (vnan_pkg::Q_W'(1) << k_r);
  assign q_new    = (mul_acc <= tgt_r) ? trial : q_r;
  assign is_degen = mul_acc <= PW'(min_len_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vnan_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_if.cmd)
            vnan_pkg::CMD_CLEAR: state_nxt = vnan_pkg::ST_CLR;
            vnan_pkg::CMD_ACCUM: state_nxt = vnan_pkg::ST_ACC_RD;
            vnan_pkg::CMD_READ:  state_nxt = vnan_pkg::ST_RD_MEM;
            // unused command returns zeros through the clear path, no write
            default:             state_nxt = vnan_pkg::ST_CLR;
          endcase
        end
      end
      vnan_pkg::ST_CLR:      state_nxt = vnan_pkg::ST_IDLE;
      vnan_pkg::ST_ACC_RD:   state_nxt = vnan_pkg::ST_ACC_WR;
      vnan_pkg::ST_ACC_WR:   state_nxt = (v_r == 2'd2) ? vnan_pkg::ST_IDLE : vnan_pkg::ST_ACC_RD;
      vnan_pkg::ST_RD_MEM:   state_nxt = vnan_pkg::ST_RD_WAIT;
      vnan_pkg::ST_RD_WAIT:  state_nxt = vnan_pkg::ST_SQ_START;
      vnan_pkg::ST_SQ_START: state_nxt = vnan_pkg::ST_SQ_RUN;
      vnan_pkg::ST_SQ_RUN: begin
        if (!mul_busy) begin
          state_nxt = (j_r == 2'd2) ? vnan_pkg::ST_DEG_CHK : vnan_pkg::ST_SQ_START;
        end
      end
      vnan_pkg::ST_DEG_CHK:  state_nxt = is_degen ? vnan_pkg::ST_IDLE : vnan_pkg::ST_T_START;
      vnan_pkg::ST_T_START:  state_nxt = vnan_pkg::ST_T_RUN;
      vnan_pkg::ST_T_RUN:    state_nxt = mul_busy ? vnan_pkg::ST_T_RUN : vnan_pkg::ST_C2_START;
      vnan_pkg::ST_C2_START: state_nxt = vnan_pkg::ST_C2_RUN;
      vnan_pkg::ST_C2_RUN:   state_nxt = mul_busy ? vnan_pkg::ST_C2_RUN : vnan_pkg::ST_CL_START;
      vnan_pkg::ST_CL_START: state_nxt = vnan_pkg::ST_CL_RUN;
      vnan_pkg::ST_CL_RUN:   state_nxt = mul_busy ? vnan_pkg::ST_CL_RUN : vnan_pkg::ST_CMP;
      vnan_pkg::ST_CMP: begin
        if (k_r != '0) begin
          state_nxt = vnan_pkg::ST_C2_START;
        end else if (j_r == 2'd2) begin
          state_nxt = vnan_pkg::ST_IDLE;
        end else begin
          state_nxt = vnan_pkg::ST_T_START;
        end
      end
      default: state_nxt = vnan_pkg::ST_IDLE;
    endcase
    // a finished command waits for the output register
    if (done && !out_free) begin
      state_nxt = state_r;
    end
  end

  // outputs of the sequencer
  always_comb begin
    mem_we         = 1'b0;
    mem_wd         = sat_sum;
    mul_ctl.start  = 1'b0;
    mul_ctl.len    = vnan_pkg::CNT_W'(SW);
    mul_init       = '0;
    mul_mcand      = PW'(mag_r[j_r]);
    mul_mplier     = MPW'(mag_r[j_r]);
    done           = 1'b0;
    case (state_r)
      vnan_pkg::ST_IDLE: begin
        done = 1'b0;
      end
      vnan_pkg::ST_CLR: begin
        mem_we = vsel_inr && out_free && (cmd_r == vnan_pkg::CMD_CLEAR);
        mem_wd = '0;
        done   = 1'b1;
      end
      vnan_pkg::ST_ACC_WR: begin
        mem_we = vsel_inr && !((v_r == 2'd2) && !out_free);
        done   = (v_r == 2'd2);
      end
      vnan_pkg::ST_SQ_START: begin
        mul_ctl.start = 1'b1;
        mul_init      = (j_r == 2'd0) ? '0 : mul_acc;
      end
      vnan_pkg::ST_DEG_CHK: begin
        done = is_degen;
      end
      vnan_pkg::ST_T_START: begin
        mul_ctl.start = 1'b1;
      end
      vnan_pkg::ST_C2_START: begin
        mul_ctl.start = 1'b1;
        mul_ctl.len   = vnan_pkg::CNT_W'(vnan_pkg::Q_W);
        mul_mcand     = PW'(trial);
        mul_mplier    = MPW'(trial);
      end
      vnan_pkg::ST_CL_START: begin
        mul_ctl.start = 1'b1;
        mul_ctl.len   = vnan_pkg::CNT_W'(vnan_pkg::C2_W);
        mul_mcand     = len2_r;
        mul_mplier    = MPW'(mul_acc[vnan_pkg::C2_W-1:0]);
      end
      vnan_pkg::ST_CMP: begin
        done = (k_r == '0) && (j_r == 2'd2);
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vnan_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      vnan_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_r     <= in_if.cmd;
          vtx_r[0]  <= in_if.vertex_a;
          vtx_r[1]  <= in_if.vertex_b;
          vtx_r[2]  <= in_if.vertex_c;
          face_r[0] <= in_if.face_x;
          face_r[1] <= in_if.face_y;
          face_r[2] <= in_if.face_z;
          v_r       <= 2'd0;
          j_r       <= 2'd0;
          degen_r   <= 1'b0;
          ovf_r     <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            res_r[i] <= '0;
          end
        end
      end
      vnan_pkg::ST_ACC_WR: begin
        if (vsel_inr && sat_ovf) begin
          ovf_r <= 1'b1;
        end
        if (v_r != 2'd2) begin
          v_r <= v_r + 1'b1;
        end
      end
      vnan_pkg::ST_RD_MEM: begin
        inr_r <= vsel_inr;
      end
      vnan_pkg::ST_RD_WAIT: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= rd_mag[i];
          neg_r[i] <= rd_neg[i];
        end
      end
      vnan_pkg::ST_SQ_RUN: begin
        if (!mul_busy && (j_r != 2'd2)) begin
          j_r <= j_r + 1'b1;
        end
      end
      vnan_pkg::ST_DEG_CHK: begin
        len2_r  <= mul_acc;
        degen_r <= is_degen;
        j_r     <= 2'd0;
        k_r     <= 4'(vnan_pkg::FRAC_W);
        q_r     <= '0;
      end
      vnan_pkg::ST_T_RUN: begin
        tgt_r <= mul_acc << (2 * vnan_pkg::FRAC_W);
      end
      vnan_pkg::ST_CMP: begin
        if (k_r != '0) begin
          q_r <= q_new;
          k_r <= k_r - 1'b1;
        end else if (!done || out_free) begin
          res_r[j_r] <= neg_r[j_r] ? -vnan_pkg::UNIT_W'(q_new) : vnan_pkg::UNIT_W'(q_new);
          q_r        <= '0;
          k_r        <= 4'(vnan_pkg::FRAC_W);
          if (j_r != 2'd2) begin
            j_r <= j_r + 1'b1;
          end
        end
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

  // result selection at completion; the last component is bypassed
  logic signed [vnan_pkg::UNIT_W-1:0] fin_unit [3];
  logic                               fin_degen;
  logic                               fin_ovf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fin_unit[i] = res_r[i];
    end
    fin_degen = 1'b0;
    fin_ovf   = 1'b0;
    case (state_r)
      vnan_pkg::ST_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          fin_unit[i] = '0;
        end
      end
      vnan_pkg::ST_CLR: begin
        fin_degen = 1'b0;
      end
      vnan_pkg::ST_ACC_WR: begin
        fin_ovf = ovf_r || (vsel_inr && sat_ovf);
      end
      vnan_pkg::ST_DEG_CHK: begin
        fin_degen = 1'b1;
      end
      vnan_pkg::ST_CMP: begin
        fin_unit[2] = neg_r[2] ? -vnan_pkg::UNIT_W'(q_new) : vnan_pkg::UNIT_W'(q_new);
      end
      default: begin
        fin_degen = degen_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      for (int i = 0; i < 3; i++) begin
        out_unit_r[i] <= fin_unit[i];
      end
      out_degen_r <= fin_degen;
      out_ovf_r   <= fin_ovf;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.unit_x     = out_unit_r[0];
  assign out_if.unit_y     = out_unit_r[1];
  assign out_if.unit_z     = out_unit_r[2];
  assign out_if.degenerate = out_degen_r;
  assign out_if.overflowed = out_ovf_r;

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_degen_r && out_ovf_r))
    else $error("degenerate and overflowed set together");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_degen_r) |->
      (out_unit_r[0] == '0) && (out_unit_r[1] == '0) && (out_unit_r[2] == '0))
    else $error("degenerate result with nonzero vector");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_ctl.start |-> !mul_busy)
    else $error("multiplier started while busy");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (done && out_free) |=> out_valid_r)
    else $error("finished command did not reach output register");
`endif

endmodule
`default_nettype wire

FILE: hdl/vnan_serial_mul.sv
// bit-serial shift-add multiplier with preloadable accumulator
`timescale 1ns / 1ps
`default_nettype none
module vnan_serial_mul #(
  parameter int PW  = 80,
  parameter int MPW = 30
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire vnan_pkg::mul_ctl_t       ctl,
  input  wire logic [PW-1:0]            acc_init,
  input  wire logic [PW-1:0]            mcand_in,
  input  wire logic [MPW-1:0]           mplier_in,
  output logic      [PW-1:0]            acc_out,
  output logic                          busy
);

  logic [PW-1:0]              acc_r;
  logic [PW-1:0]              mcand_r;
  logic [MPW-1:0]             mplier_r;
  logic [vnan_pkg::CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.start) begin
      cnt_r <= ctl.len;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r    <= acc_init;
      mcand_r  <= mcand_in;
      mplier_r <= mplier_in;
    end else if (cnt_r != '0) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign acc_out = acc_r;
  assign busy    = (cnt_r != '0);

endmodule
`default_nettype wire
